### design/afd_pkg.sv
// Shared types and constants for the serial frame deframer.
package afd_pkg;

  localparam int AxisCountDefault = 5;
  localparam int NumAxisOut       = 5;
  localparam int AxisW            = 9;
  localparam int ByteW            = 8;
  localparam int AddrW            = 3;
  localparam int DataW            = 32;

  localparam logic [ByteW-1:0] StartMarkerReset = 8'h7E;
  localparam logic [ByteW-1:0] AbortMarkerReset = 8'h0A;

  // register index, taken from paddr[2]
  localparam logic RegStart = 1'b0;
  localparam logic RegAbort = 1'b1;

  // one decoded byte: store update and frame flags
  typedef struct packed {
    logic                    wr_en;
    logic [ByteW-1:0]        wr_id;
    logic signed [AxisW-1:0] wr_value;
    logic                    complete;
    logic                    aborted;
  } afd_upd_t;

endpackage

### design/axis_frame_deframer_unit.sv
// Top level of the serial frame deframer: input register, parser, store, result flags, APB.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | rx_byte
//   out     | output    | out_valid/out_stall | axis_0..axis_4, frame_complete, frame_aborted
//   cfg     | input     | APB psel/penable    | start_marker (0x0), abort_marker (0x4)
//
// A byte is held in the input register, passes the single parse step and its result is registered;
// one byte per cycle is sustained while out_stall does not hold the result.
// Reset clears the phase, the captured id and sign, all axis values and both markers
// to their defaults. A stalled result holds the axis values and flags; the input register
// keeps accepting until it is full behind it.
module axis_frame_deframer_unit #(
  parameter int AXIS_COUNT = afd_pkg::AxisCountDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [afd_pkg::ByteW-1:0]          rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [afd_pkg::AxisW-1:0]   axis_0,
  output logic signed [afd_pkg::AxisW-1:0]   axis_1,
  output logic signed [afd_pkg::AxisW-1:0]   axis_2,
  output logic signed [afd_pkg::AxisW-1:0]   axis_3,
  output logic signed [afd_pkg::AxisW-1:0]   axis_4,
  output logic                               frame_complete,
  output logic                               frame_aborted,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [afd_pkg::AddrW-1:0]          paddr,
  input  logic [afd_pkg::DataW-1:0]          pwdata,
  output logic [afd_pkg::DataW-1:0]          prdata,
  output logic                               pready
);
  import afd_pkg::*;

  logic [ByteW-1:0]        start_marker;
  logic [ByteW-1:0]        abort_marker;
  logic                    in_full;
  logic [ByteW-1:0]        in_byte;
  logic                    advance;
  afd_upd_t                upd;
  logic signed [AxisW-1:0] axis_out [NumAxisOut];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegAbort) ? DataW'(abort_marker) : DataW'(start_marker);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= StartMarkerReset;
      abort_marker <= AbortMarkerReset;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        RegStart: start_marker <= pwdata[ByteW-1:0];
        RegAbort: abort_marker <= pwdata[ByteW-1:0];
        default:  ;
      endcase
    end
  end

  // advance the held byte whenever the result register is free or being drained
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte <= rx_byte;
  end

  afd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .rx_byte      (in_byte),
    .start_marker (start_marker),
    .abort_marker (abort_marker),
    .upd          (upd)
  );

  afd_axis_store #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .upd      (upd),
    .axis_out (axis_out)
  );

  // result flags; the axis values are the store itself and update in the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_complete <= upd.complete;
      frame_aborted  <= upd.aborted;
    end
  end

  assign axis_0 = axis_out[0];
  assign axis_1 = axis_out[1];
  assign axis_2 = axis_out[2];
  assign axis_3 = axis_out[3];
  assign axis_4 = axis_out[4];

endmodule

### design/afd_parser.sv
// Frame parser: phase tracking, id and sign capture, per-byte decode.
module afd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            start_marker,
  input  logic [7:0]            abort_marker,
  output afd_pkg::afd_upd_t     upd
);
  import afd_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_ID,
    PH_SIGN,
    PH_MAG
  } phase_t;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] captured_id, captured_id_next;
  logic             captured_negative, captured_negative_next;
  logic             is_abort;

  assign is_abort = (rx_byte == abort_marker);

  always_comb begin
    phase_next             = phase;
    captured_id_next       = captured_id;
    captured_negative_next = captured_negative;
    upd.wr_en              = 1'b0;
    upd.wr_id              = captured_id;
    upd.complete           = 1'b0;
    upd.aborted            = 1'b0;
    // negate as a 9-bit value; zero magnitude stays zero
    upd.wr_value = captured_negative ? -$signed({1'b0, rx_byte}) : $signed({1'b0, rx_byte});
    case (phase)
      PH_WAIT: begin
        if (rx_byte == start_marker) phase_next = PH_ID;
      end
      PH_ID: begin
        if (is_abort) begin
          upd.aborted = 1'b1;
          phase_next  = PH_WAIT;
        end else begin
          captured_id_next = rx_byte;
          phase_next       = PH_SIGN;
        end
      end
      PH_SIGN: begin
        if (is_abort) begin
          upd.aborted = 1'b1;
          phase_next  = PH_WAIT;
        end else begin
          captured_negative_next = (rx_byte == '0);
          phase_next             = PH_MAG;
        end
      end
      PH_MAG: begin
        if (is_abort) begin
          upd.aborted = 1'b1;
        end else begin
          upd.complete = 1'b1;
          upd.wr_en    = 1'b1;
        end
        phase_next = PH_WAIT;
      end
      default: phase_next = PH_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAIT;
      captured_id       <= '0;
      captured_negative <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      captured_id       <= captured_id_next;
      captured_negative <= captured_negative_next;
    end
  end

endmodule

### design/afd_axis_store.sv
// Axis value registers, written on a completed frame with an id in range.
module afd_axis_store #(
  parameter int AXIS_COUNT = afd_pkg::AxisCountDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  afd_pkg::afd_upd_t            upd,
  output logic signed [afd_pkg::AxisW-1:0] axis_out [afd_pkg::NumAxisOut]
);
  import afd_pkg::*;

  logic signed [AxisW-1:0] store [AXIS_COUNT];

  // ids at or above AXIS_COUNT match no entry and leave the store alone
  always_ff @(posedge clk) begin
    for (int j = 0; j < AXIS_COUNT; j++) begin
      if (rst) begin
        store[j] <= '0;
      end else if (advance && upd.wr_en && (upd.wr_id == ByteW'(j))) begin
        store[j] <= upd.wr_value;
      end
    end
  end

  for (genvar j = 0; j < NumAxisOut; j++) begin : g_out
    if (j < AXIS_COUNT) begin : g_live
      assign axis_out[j] = store[j];
    end else begin : g_zero
      assign axis_out[j] = '0;
    end
  end

endmodule

### dv/tb.sv
// Self-checking testbench for the serial frame deframer: directed, random and stalled traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afd_pkg::*;

  typedef enum logic [1:0] {
    PhWait,
    PhId,
    PhSign,
    PhMag
  } parse_phase_t;

  typedef struct packed {
    logic [NumAxisOut-1:0][AxisW-1:0] axis;
    logic                             complete;
    logic                             aborted;
  } deframe_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] rx_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic signed [AxisW-1:0] axis_0, axis_1, axis_2, axis_3, axis_4;
  logic             frame_complete;
  logic             frame_aborted;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // predictor state
  parse_phase_t            phase_q = PhWait;
  logic [ByteW-1:0]        cap_id = '0;
  logic                    cap_neg = 1'b0;
  logic signed [AxisW-1:0] axis_model [AxisCountDefault];
  logic [ByteW-1:0]        start_byte = StartMarkerReset;
  logic [ByteW-1:0]        abort_byte = AbortMarkerReset;

  deframe_result_t expected_results [$];
  int unsigned     sent_count = 0;
  int unsigned     fail_count = 0;
  int unsigned     in_idle_pct = 32;
  int unsigned     out_idle_pct = 32;
  int unsigned     hold_req = 0;
  int unsigned     hold_len = 0;

  axis_frame_deframer_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .axis_0        (axis_0),
    .axis_1        (axis_1),
    .axis_2        (axis_2),
    .axis_3        (axis_3),
    .axis_4        (axis_4),
    .frame_complete(frame_complete),
    .frame_aborted (frame_aborted),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    foreach (axis_model[k]) axis_model[k] = '0;
  end

  // Advance the deframer model by one byte and return the result it produces.
  function automatic deframe_result_t decode_byte(input logic [ByteW-1:0] b);
    deframe_result_t r;
    r = '0;
    case (phase_q)
      PhWait: begin
        if (b == start_byte) phase_q = PhId;
      end
      PhId: begin
        if (b == abort_byte) begin
          r.aborted = 1'b1;
          phase_q = PhWait;
        end else begin
          cap_id = b;
          phase_q = PhSign;
        end
      end
      PhSign: begin
        if (b == abort_byte) begin
          r.aborted = 1'b1;
          phase_q = PhWait;
        end else begin
          cap_neg = (b == 8'h00);
          phase_q = PhMag;
        end
      end
      default: begin
        if (b == abort_byte) begin
          r.aborted = 1'b1;
        end else begin
          r.complete = 1'b1;
          if (cap_id < AxisCountDefault)
            axis_model[cap_id] = cap_neg ? -$signed({1'b0, b}) : $signed({1'b0, b});
        end
        phase_q = PhWait;
      end
    endcase
    for (int k = 0; k < NumAxisOut; k++)
      r.axis[k] = (k < AxisCountDefault) ? axis_model[k] : '0;
    return r;
  endfunction

  function automatic logic [ByteW-1:0] pick_data(input int unsigned hi);
    logic [ByteW-1:0] v;
    do v = ByteW'($urandom_range(hi)); while (v == abort_byte);
    return v;
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_results.insert(expected_results.size(), decode_byte(b));
    sent_count++;
  endtask

  task automatic send_frame(input logic [ByteW-1:0] id, input logic [ByteW-1:0] sgn,
                            input logic [ByteW-1:0] mag);
    send_byte(start_byte);
    send_byte(id);
    send_byte(sgn);
    send_byte(mag);
  endtask

  // Mostly well-formed frames, some cut short by the abort byte, some noise.
  task automatic send_random_frame();
    int unsigned      kind;
    int unsigned      cut;
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] sgn;
    logic [ByteW-1:0] mag;
    kind = $urandom_range(99);
    id   = ($urandom_range(3) != 0) ? pick_data(AxisCountDefault - 1) : pick_data(255);
    sgn  = (abort_byte != 8'h00 && $urandom_range(1) == 0) ? 8'h00 : pick_data(255);
    mag  = pick_data(255);
    if (kind < 12) begin
      repeat ($urandom_range(4, 1)) send_byte(ByteW'($urandom_range(255)));
    end else if (kind < 24) begin
      cut = $urandom_range(3, 1);
      send_byte(start_byte);
      send_byte(cut == 1 ? abort_byte : id);
      if (cut > 1) send_byte(cut == 2 ? abort_byte : sgn);
      if (cut > 2) send_byte(abort_byte);
    end else begin
      send_frame(id, sgn, mag);
    end
  endtask

  task automatic run_random_frames(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) send_random_frame();
  endtask

  // Hold the input until every pending result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [ByteW-1:0] value);
    logic [DataW-1:0] data;
    data = $urandom;
    data[ByteW-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == RegStart) start_byte = value;
    else abort_byte = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // return to idle between transfers
    @(posedge clk);
  endtask

  task automatic set_markers(input logic [ByteW-1:0] s, input logic [ByteW-1:0] a);
    drain();
    apb_write(RegStart, s);
    apb_write(RegAbort, a);
  endtask

  task automatic test_directed();
    send_byte(abort_byte);
    send_frame(8'h00, 8'h01, start_byte);
    send_frame(8'h04, 8'h00, 8'hFF);
    send_frame(start_byte, start_byte, 8'h80);
    send_byte(start_byte);
    send_byte(abort_byte);
    send_byte(start_byte);
    send_byte(8'h02);
    send_byte(abort_byte);
    send_byte(start_byte);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(abort_byte);
    send_frame(8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_equal_markers();
    set_markers(8'h33, 8'h33);
    send_byte(8'h33);
    send_byte(8'h33);
    send_byte(8'h33);
    send_byte(8'h01);
    send_byte(8'h33);
    run_random_frames(200);
  endtask

  task automatic test_marker_settings();
    set_markers(8'h00, 8'hFF);
    run_random_frames(300);
    set_markers(8'hFF, 8'h00);
    run_random_frames(300);
    set_markers(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)));
    run_random_frames(300);
    set_markers(StartMarkerReset, AbortMarkerReset);
    run_random_frames(300);
  endtask

  task automatic test_streaming();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random_frames(200);
    in_idle_pct  = 32;
    out_idle_pct = 32;
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    hold_req++;
    in_idle_pct = 0;
    run_random_frames(40);
    in_idle_pct = 32;
    drain();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int unsigned served;
    int unsigned left;
    served = 0;
    left   = 0;
    forever begin
      @(posedge clk);
      if (served != hold_req) begin
        served = hold_req;
        left   = hold_len;
      end
      if (left != 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    deframe_result_t got;
    deframe_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.axis     = {axis_4, axis_3, axis_2, axis_1, axis_0};
      got.complete = frame_complete;
      got.aborted  = frame_aborted;
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with none pending", $time);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        for (int k = 0; k < NumAxisOut; k++) begin
          if (got.axis[k] !== want.axis[k]) begin
            $display("%0t: axis_%0d expected %0d, got %0d", $time, k,
                     $signed(want.axis[k]), $signed(got.axis[k]));
            fail_count++;
          end
        end
        if (got.complete !== want.complete) begin
          $display("%0t: frame_complete expected %0b, got %0b", $time,
                   want.complete, got.complete);
          fail_count++;
        end
        if (got.aborted !== want.aborted) begin
          $display("%0t: frame_aborted expected %0b, got %0b", $time,
                   want.aborted, got.aborted);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_equal_markers();
    test_marker_settings();
    test_streaming();
    test_backpressure();
    drain();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
